// ----- sv/ycbcr_to_rgb_chroma_upsample_unit_defines.svh -----
// Assertion helpers for the color conversion unit.
// Each macro samples on clk_i and is disabled while rst_ni is low.
`ifndef YCBCR_TO_RGB_CHROMA_UPSAMPLE_UNIT_DEFINES_SVH
`define YCBCR_TO_RGB_CHROMA_UPSAMPLE_UNIT_DEFINES_SVH

// Same-cycle implication.
`define YCC_ASSERT_NOW(lbl, pre, post) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (pre) |-> (post)) \
    else $error("ycc assertion failed");

// Next-cycle implication.
`define YCC_ASSERT_NEXT(lbl, pre, post) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (pre) |=> (post)) \
    else $error("ycc assertion failed");

`endif

// ----- sv/ycc_pkg.sv -----
`timescale 1ns / 1ps
package ycc_pkg;

  // Sample and store geometry
  localparam int SAMPLE_W     = 12;
  localparam int PIX_IDX_W    = 6;
  localparam int CHROMA_DEPTH = 64;
  localparam int COLOR_W      = 8;
  localparam int CFG_IDX_W    = 2;
  localparam int SAMP_W       = 2;

  // Q16 arithmetic
  localparam int Q_FRAC  = 16;
  localparam int COEF_W  = 18;
  localparam int PROD_W  = SAMPLE_W + COEF_W;
  localparam int SUM_W   = PROD_W + 2;

  localparam logic signed [COEF_W-1:0] COEF_CR_R = 18'sd91881;
  localparam logic signed [COEF_W-1:0] COEF_CB_G = 18'sd22544;
  localparam logic signed [COEF_W-1:0] COEF_CR_G = 18'sd46793;
  localparam logic signed [COEF_W-1:0] COEF_CB_B = 18'sd116130;
  localparam logic signed [COEF_W-1:0] LUMA_OFFSET = 18'sd128;

  // Sampling factor that halves the chroma coordinate
  localparam logic [SAMP_W-1:0] SAMP_HALF  = 2'd2;
  localparam logic [SAMP_W-1:0] SAMP_RESET = 2'd1;

  typedef enum logic {
    OP_LOAD    = 1'b0,
    OP_CONVERT = 1'b1
  } op_e;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_VERT_SAMPLING  = 2'd0,
    REG_HORIZ_SAMPLING = 2'd1
  } cfg_reg_e;

  typedef struct packed {
    op_e                         operation;
    logic [PIX_IDX_W-1:0]        pixel_index;
    logic signed [SAMPLE_W-1:0]  luma;
    logic signed [SAMPLE_W-1:0]  chroma_blue;
    logic signed [SAMPLE_W-1:0]  chroma_red;
    logic                        block_row;
    logic                        block_col;
  } in_item_t;

  typedef struct packed {
    logic [PIX_IDX_W-1:0] out_index;
    logic [COLOR_W-1:0]   red;
    logic [COLOR_W-1:0]   green;
    logic [COLOR_W-1:0]   blue;
  } out_item_t;

  typedef struct packed {
    logic [CFG_IDX_W-1:0] index;
    logic [SAMP_W-1:0]    value;
  } cfg_item_t;

endpackage

// ----- sv/ycc_if.sv -----
`timescale 1ns / 1ps
// Input item channel
interface ycc_in_if;
  import ycc_pkg::*;
  logic     valid;
  logic     ready;
  in_item_t data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

// Result item channel
interface ycc_out_if;
  import ycc_pkg::*;
  logic      valid;
  logic      ready;
  out_item_t data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

// Register write channel
interface ycc_cfg_if;
  import ycc_pkg::*;
  logic      valid;
  logic      ready;
  cfg_item_t data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

// ----- sv/ycbcr_to_rgb_chroma_upsample_unit.sv -----
// Path: a convert result is registered in the store read, multiply and output
//   registers in order, then is valid and can transfer; a stall holds it in place.
// Throughput: one item per cycle while not stalled; a three-stage pipeline (store read,
//   multiply, sum and clamp) advances as a whole whenever the output register is free or being drained.
// Reset: clears valid bits and sets both sampling factors to 1; the chroma
//   store is not cleared and holds garbage until loaded.
`timescale 1ns / 1ps
`include "ycbcr_to_rgb_chroma_upsample_unit_defines.svh"
module ycbcr_to_rgb_chroma_upsample_unit
  import ycc_pkg::*;
(
  input  logic      clk_i,
  input  logic      rst_ni,
  ycc_in_if.sink    in_if,
  ycc_cfg_if.sink   cfg_if,
  ycc_out_if.source out_if
);

  // Configuration registers
  logic [SAMP_W-1:0] vert_q, horiz_q;

  // Pipeline control
  logic adv;
  logic in_acc;
  logic s1_vld_q, s2_vld_q, out_vld_q;

  // Store read stage
  logic [2*SAMPLE_W-1:0]      chroma_mem_q [CHROMA_DEPTH];
  logic [2*SAMPLE_W-1:0]      s1_chroma_q;
  logic signed [SAMPLE_W-1:0] s1_luma_q;
  logic [PIX_IDX_W-1:0]       s1_idx_q;
  logic [2:0]                 row, col, crow_d, ccol_d;
  logic [PIX_IDX_W-1:0]       rd_idx_d;
  logic signed [SAMPLE_W-1:0] s1_cb, s1_cr;

  // Multiply stage
  logic signed [PROD_W-1:0] base_d, base_q;
  logic signed [PROD_W-1:0] p_cr_r_d, p_cb_g_d, p_cr_g_d, p_cb_b_d;
  logic signed [PROD_W-1:0] p_cr_r_q, p_cb_g_q, p_cr_g_q, p_cb_b_q;
  logic [PIX_IDX_W-1:0]     s2_idx_q;

  // Sum stage
  logic signed [SUM_W-1:0] sum_r, sum_g, sum_b;
  out_item_t               out_d, out_q;

  function automatic logic [COLOR_W-1:0] clamp_q16(input logic signed [SUM_W-1:0] s);
    logic [COLOR_W-1:0] v;
    if (s[SUM_W-1]) begin
      v = '0;
    end else if (|s[SUM_W-2:Q_FRAC+COLOR_W]) begin
      v = '1;
    end else begin
      v = s[Q_FRAC+COLOR_W-1:Q_FRAC];
    end
    return v;
  endfunction

  // Advance when the output register is empty or being drained
  assign adv          = !out_vld_q || out_if.ready;
  assign in_if.ready  = adv;
  assign in_acc       = in_if.valid && adv;
  assign cfg_if.ready = 1'b1;

  // Write sampling factors; other indexes are dropped
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vert_q  <= SAMP_RESET;
      horiz_q <= SAMP_RESET;
    end else if (cfg_if.valid) begin
      unique case (cfg_if.data.index)
        REG_VERT_SAMPLING:  vert_q  <= cfg_if.data.value;
        REG_HORIZ_SAMPLING: horiz_q <= cfg_if.data.value;
        default: ;
      endcase
    end
  end

  // Map the luma pixel to its chroma pixel
  always_comb begin
    row      = in_if.data.pixel_index[5:3];
    col      = in_if.data.pixel_index[2:0];
    crow_d   = ((vert_q == SAMP_HALF) ? (row >> 1) : row) + {in_if.data.block_row, 2'b00};
    ccol_d   = ((horiz_q == SAMP_HALF) ? (col >> 1) : col) + {in_if.data.block_col, 2'b00};
    rd_idx_d = {crow_d, ccol_d};
  end

  // Chroma store: write on load transfers, registered read on every advance
  always_ff @(posedge clk_i) begin
    if (in_acc && in_if.data.operation == OP_LOAD) begin
      chroma_mem_q[in_if.data.pixel_index] <= {in_if.data.chroma_blue, in_if.data.chroma_red};
    end
    if (adv) begin
      s1_chroma_q <= chroma_mem_q[rd_idx_d];
      s1_luma_q   <= in_if.data.luma;
      s1_idx_q    <= in_if.data.pixel_index;
    end
  end

  assign s1_cb = s1_chroma_q[2*SAMPLE_W-1:SAMPLE_W];
  assign s1_cr = s1_chroma_q[SAMPLE_W-1:0];

  // Form the luma term and the constant products
  always_comb begin
    base_d   = (PROD_W'(s1_luma_q) + PROD_W'(LUMA_OFFSET)) <<< Q_FRAC;
    p_cr_r_d = PROD_W'(s1_cr) * PROD_W'(COEF_CR_R);
    p_cb_g_d = PROD_W'(s1_cb) * PROD_W'(COEF_CB_G);
    p_cr_g_d = PROD_W'(s1_cr) * PROD_W'(COEF_CR_G);
    p_cb_b_d = PROD_W'(s1_cb) * PROD_W'(COEF_CB_B);
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      base_q   <= base_d;
      p_cr_r_q <= p_cr_r_d;
      p_cb_g_q <= p_cb_g_d;
      p_cr_g_q <= p_cr_g_d;
      p_cb_b_q <= p_cb_b_d;
      s2_idx_q <= s1_idx_q;
    end
  end

  // Sum in Q16, then clamp to 0..255
  always_comb begin
    sum_r = SUM_W'(base_q) + SUM_W'(p_cr_r_q);
    sum_g = SUM_W'(base_q) - SUM_W'(p_cb_g_q) - SUM_W'(p_cr_g_q);
    sum_b = SUM_W'(base_q) + SUM_W'(p_cb_b_q);
    out_d.out_index = s2_idx_q;
    out_d.red       = clamp_q16(sum_r);
    out_d.green     = clamp_q16(sum_g);
    out_d.blue      = clamp_q16(sum_b);
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      out_q <= out_d;
    end
  end

  // Valid bits: loads enter as bubbles
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_vld_q  <= 1'b0;
      s2_vld_q  <= 1'b0;
      out_vld_q <= 1'b0;
    end else if (adv) begin
      s1_vld_q  <= in_if.valid && (in_if.data.operation == OP_CONVERT);
      s2_vld_q  <= s1_vld_q;
      out_vld_q <= s2_vld_q;
    end
  end

  assign out_if.valid = out_vld_q;
  assign out_if.data  = out_q;

  // Convert transfers enter the pipeline, load transfers do not
  `YCC_ASSERT_NEXT(a_convert_enters, in_acc && in_if.data.operation == OP_CONVERT, s1_vld_q)
  `YCC_ASSERT_NEXT(a_load_no_result, in_acc && in_if.data.operation == OP_LOAD, !s1_vld_q)
  // A full multiply stage reaches the output on advance
  `YCC_ASSERT_NEXT(a_s2_to_out, s2_vld_q && adv, out_vld_q)
  // Stalled pipeline keeps its valid bits
  `YCC_ASSERT_NEXT(a_stall_holds, !adv, $stable(s1_vld_q) && $stable(s2_vld_q))
  // No input is taken while the output waits
  `YCC_ASSERT_NOW(a_no_take_on_stall, out_vld_q && !out_if.ready, !in_if.ready)

endmodule

// ----- dv/testbench.sv -----
`timescale 1ns / 1ps
module testbench;
  import ycc_pkg::*;

  typedef logic signed [SAMPLE_W-1:0] sample_t;

  // Q16 color coefficients
  localparam longint Q16_CR_R = 91881;
  localparam longint Q16_CB_G = 22544;
  localparam longint Q16_CR_G = 46793;
  localparam longint Q16_CB_B = 116130;

  // Register indexes with no register behind them
  localparam logic [CFG_IDX_W-1:0] REG_SPARE_A = 2'd2;
  localparam logic [CFG_IDX_W-1:0] REG_SPARE_B = 2'd3;

  // Sampling factor codes that act as no division
  localparam logic [SAMP_W-1:0] SAMP_ZERO  = 2'd0;
  localparam logic [SAMP_W-1:0] SAMP_THREE = 2'd3;

  localparam int IDLE_PERCENT = 22;
  localparam int SETTLE_CYCLES = 6;
  localparam int RANDOM_ITEMS = 130;
  localparam int CYCLE_LIMIT = 400000;

  logic clk_i = 1'b0;
  logic rst_ni;
  bit steady = 1'b0;
  int error_count = 0;
  int cycle_count = 0;

  // Shadow state: chroma stores and sampling factors
  sample_t cb_mem [CHROMA_DEPTH];
  sample_t cr_mem [CHROMA_DEPTH];
  logic [SAMP_W-1:0] vert_factor = SAMP_RESET;
  logic [SAMP_W-1:0] horiz_factor = SAMP_RESET;
  out_item_t rgb_expected[$];

  ycc_in_if  pix_in ();
  ycc_cfg_if cfg_wr ();
  ycc_out_if rgb_out ();

  ycbcr_to_rgb_chroma_upsample_unit DUT (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .in_if  (pix_in),
    .cfg_if (cfg_wr),
    .out_if (rgb_out)
  );

  always begin
    #10 clk_i = 1'b1;
    #10 clk_i = 1'b0;
  end

  // Bound the run
  always @(posedge clk_i) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("Some tests failed");
      $finish;
    end
  end

  // Stall the result channel at random unless in a steady stretch
  always @(negedge clk_i) begin
    rgb_out.ready <= steady || ($urandom_range(0, 99) >= IDLE_PERCENT);
  end

  // Truncate a Q16 sum and clamp to one color byte
  function automatic logic [COLOR_W-1:0] clamp_color(longint sum);
    longint whole;
    if (sum < 0) return '0;
    whole = sum >>> 16;
    if (whole > 255) return 8'd255;
    return whole[COLOR_W-1:0];
  endfunction

  // Upsample chroma for one luma pixel and convert to RGB
  function automatic out_item_t convert_pixel(in_item_t item);
    logic [2:0] crow;
    logic [2:0] ccol;
    logic [PIX_IDX_W-1:0] cidx;
    longint y;
    longint cb;
    longint cr;
    longint base;
    out_item_t res;
    crow = item.pixel_index[5:3];
    ccol = item.pixel_index[2:0];
    if (vert_factor == SAMP_HALF) crow = crow >> 1;
    if (horiz_factor == SAMP_HALF) ccol = ccol >> 1;
    // wrap past the block edge within three bits
    crow = crow + (item.block_row ? 3'd4 : 3'd0);
    ccol = ccol + (item.block_col ? 3'd4 : 3'd0);
    cidx = {crow, ccol};
    y = longint'($signed(item.luma));
    cb = longint'(cb_mem[cidx]);
    cr = longint'(cr_mem[cidx]);
    base = (y + 128) * 65536;
    res.out_index = item.pixel_index;
    res.red = clamp_color(base + Q16_CR_R * cr);
    res.green = clamp_color(base - Q16_CB_G * cb - Q16_CR_G * cr);
    res.blue = clamp_color(base + Q16_CB_B * cb);
    return res;
  endfunction

  function automatic void check_field(string field, int unsigned want, int unsigned got);
    if (want != got) begin
      $display("%0t: %s mismatch, expected %0d, got %0d", $time, field, want, got);
      error_count++;
    end
  endfunction

  // Check each result transfer, then track input and register transfers
  always @(posedge clk_i) begin
    out_item_t got;
    out_item_t want;
    if (rst_ni) begin
      if (rgb_out.valid && rgb_out.ready) begin
        got = rgb_out.data;
        if (rgb_expected.size() == 0) begin
          $display("%0t: unexpected result, expected none, got index %0d rgb %0d %0d %0d",
                   $time, got.out_index, got.red, got.green, got.blue);
          error_count++;
        end else begin
          want = rgb_expected.pop_front();
          check_field("out_index", want.out_index, got.out_index);
          check_field("red", want.red, got.red);
          check_field("green", want.green, got.green);
          check_field("blue", want.blue, got.blue);
        end
      end
      if (pix_in.valid && pix_in.ready) begin
        if (pix_in.data.operation == OP_LOAD) begin
          cb_mem[pix_in.data.pixel_index] = pix_in.data.chroma_blue;
          cr_mem[pix_in.data.pixel_index] = pix_in.data.chroma_red;
        end else begin
          rgb_expected.push_back(convert_pixel(pix_in.data));
        end
      end
      if (cfg_wr.valid && cfg_wr.ready) begin
        case (cfg_wr.data.index)
          REG_VERT_SAMPLING: begin
            vert_factor = cfg_wr.data.value;
          end
          REG_HORIZ_SAMPLING: begin
            horiz_factor = cfg_wr.data.value;
          end
          default: begin
          end
        endcase
      end
    end
  end

  function automatic in_item_t make_item(op_e op, int pix, sample_t luma, sample_t cb,
                                         sample_t cr, bit brow, bit bcol);
    in_item_t item;
    item.operation = op;
    item.pixel_index = PIX_IDX_W'(pix);
    item.luma = luma;
    item.chroma_blue = cb;
    item.chroma_red = cr;
    item.block_row = brow;
    item.block_col = bcol;
    return item;
  endfunction

  // Half full-range, half near zero so that results also land mid-range
  function automatic sample_t rand_sample();
    if ($urandom_range(0, 1) == 1) return sample_t'($urandom);
    return sample_t'(int'($urandom_range(0, 600)) - 300);
  endfunction

  // Send one item; called and returns at a falling edge
  task automatic send_item(in_item_t item);
    while (!steady && $urandom_range(0, 99) < IDLE_PERCENT) begin
      pix_in.valid <= 1'b0;
      @(negedge clk_i);
    end
    pix_in.valid <= 1'b1;
    pix_in.data <= item;
    @(posedge clk_i);
    while (!pix_in.ready) @(posedge clk_i);
    @(negedge clk_i);
  endtask

  // Hold the input until every pending pixel has come out
  task automatic wait_for_results();
    pix_in.valid <= 1'b0;
    do @(negedge clk_i); while (rgb_expected.size() != 0);
  endtask

  // Drain and let loads still in flight settle before a register write
  task automatic drain_pipeline();
    wait_for_results();
    repeat (SETTLE_CYCLES) @(negedge clk_i);
  endtask

  task automatic write_reg(logic [CFG_IDX_W-1:0] index, logic [SAMP_W-1:0] value);
    cfg_wr.valid <= 1'b1;
    cfg_wr.data <= '{index: index, value: value};
    @(posedge clk_i);
    while (!cfg_wr.ready) @(posedge clk_i);
    @(negedge clk_i);
    cfg_wr.valid <= 1'b0;
    @(negedge clk_i);
  endtask

  task automatic send_random_item();
    op_e op;
    op = ($urandom_range(0, 99) < 30) ? OP_LOAD : OP_CONVERT;
    send_item(make_item(op, $urandom_range(0, 63), rand_sample(), rand_sample(),
                        rand_sample(), 1'($urandom_range(0, 1)), 1'($urandom_range(0, 1))));
  endtask

  task automatic load_all_chroma();
    for (int p = 0; p < CHROMA_DEPTH; p++) begin
      send_item(make_item(OP_LOAD, p, rand_sample(), rand_sample(), rand_sample(),
                          1'($urandom_range(0, 1)), 1'($urandom_range(0, 1))));
    end
  endtask

  // Extreme samples, both operations and chroma wrap past the block edge
  task automatic test_directed_extremes();
    send_item(make_item(OP_LOAD, 0, 12'sd2047, -12'sd2048, -12'sd2048, 1'b1, 1'b1));
    send_item(make_item(OP_LOAD, 63, -12'sd2048, 12'sd2047, 12'sd2047, 1'b0, 1'b0));
    send_item(make_item(OP_LOAD, 36, 12'sd0, 12'sd0, 12'sd0, 1'b0, 1'b0));
    send_item(make_item(OP_LOAD, 27, 12'sd0, -12'sd2048, 12'sd2047, 1'b1, 1'b0));
    send_item(make_item(OP_CONVERT, 0, -12'sd2048, 12'sd2047, 12'sd2047, 1'b0, 1'b0));
    send_item(make_item(OP_CONVERT, 0, 12'sd2047, 12'sd0, 12'sd0, 1'b0, 1'b0));
    send_item(make_item(OP_CONVERT, 63, 12'sd2047, -12'sd2048, -12'sd2048, 1'b0, 1'b0));
    send_item(make_item(OP_CONVERT, 63, -12'sd2048, 12'sd0, 12'sd0, 1'b0, 1'b0));
    send_item(make_item(OP_CONVERT, 36, 12'sd0, 12'sd0, 12'sd0, 1'b0, 1'b0));
    send_item(make_item(OP_CONVERT, 36, 12'sd127, 12'sd0, 12'sd0, 1'b0, 1'b0));
    send_item(make_item(OP_CONVERT, 36, -12'sd129, 12'sd0, 12'sd0, 1'b0, 1'b0));
    send_item(make_item(OP_CONVERT, 0, 12'sd100, 12'sd0, 12'sd0, 1'b1, 1'b1));
    send_item(make_item(OP_CONVERT, 63, 12'sd0, 12'sd0, 12'sd0, 1'b1, 1'b1));
    send_item(make_item(OP_CONVERT, 27, -12'sd50, 12'sd0, 12'sd0, 1'b1, 1'b1));
    send_item(make_item(OP_CONVERT, 4, 12'sd10, 12'sd0, 12'sd0, 1'b1, 1'b0));
    send_item(make_item(OP_CONVERT, 32, -12'sd10, 12'sd0, 12'sd0, 1'b0, 1'b1));
  endtask

  // Write every chroma entry so that later conversions read only loaded data
  task automatic test_chroma_fill();
    load_all_chroma();
  endtask

  // One MCU in raster order, then random items under one pair of factors
  task automatic test_sampling(logic [SAMP_W-1:0] vert, logic [SAMP_W-1:0] horiz, bit quiet);
    int brow_last;
    int bcol_last;
    drain_pipeline();
    write_reg(REG_VERT_SAMPLING, vert);
    write_reg(REG_HORIZ_SAMPLING, horiz);
    steady = quiet;
    brow_last = (vert == SAMP_HALF) ? 1 : 0;
    bcol_last = (horiz == SAMP_HALF) ? 1 : 0;
    load_all_chroma();
    for (int br = 0; br <= brow_last; br++) begin
      for (int bc = 0; bc <= bcol_last; bc++) begin
        for (int p = 0; p < CHROMA_DEPTH; p++) begin
          send_item(make_item(OP_CONVERT, p, rand_sample(), rand_sample(), rand_sample(),
                              br[0], bc[0]));
        end
      end
    end
    for (int i = 0; i < RANDOM_ITEMS; i++) begin
      if (i == 60 || $urandom_range(0, 99) == 0) wait_for_results();
      send_random_item();
    end
    steady = 1'b0;
  endtask

  // Writes to indexes without a register must leave both factors alone
  task automatic test_unused_register_index();
    drain_pipeline();
    write_reg(REG_SPARE_A, SAMP_HALF);
    write_reg(REG_SPARE_B, SAMP_ZERO);
    for (int i = 0; i < 40; i++) send_random_item();
  endtask

  initial begin
    rst_ni = 1'b0;
    pix_in.valid = 1'b0;
    pix_in.data = '0;
    cfg_wr.valid = 1'b0;
    cfg_wr.data = '0;
    rgb_out.ready = 1'b0;
    repeat (2) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;
    @(negedge clk_i);

    test_directed_extremes();
    test_chroma_fill();
    test_sampling(SAMP_RESET, SAMP_RESET, 1'b0);
    test_sampling(SAMP_HALF, SAMP_HALF, 1'b1);
    test_sampling(SAMP_HALF, SAMP_RESET, 1'b0);
    test_sampling(SAMP_RESET, SAMP_HALF, 1'b0);
    test_unused_register_index();
    test_sampling(SAMP_ZERO, SAMP_THREE, 1'b0);
    test_sampling(SAMP_THREE, SAMP_ZERO, 1'b0);

    // Wait out the last results and any stray output
    drain_pipeline();
    if (error_count == 0 && rgb_expected.size() == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

endmodule

// ----- filelist.f -----
+incdir+sv
sv/ycc_pkg.sv
sv/ycc_if.sv
sv/ycbcr_to_rgb_chroma_upsample_unit.sv
dv/testbench.sv
